// ===== rtl/keyframe_linear_sampler_unit_defines.svh =====
// Assertion macros for the keyframe sampler
`ifndef KEYFRAME_LINEAR_SAMPLER_UNIT_DEFINES_SVH
`define KEYFRAME_LINEAR_SAMPLER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define KLS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");
`define KLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KLS_ASSERT(lbl, cond)
`define KLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/kls_pkg.sv =====
`default_nettype none
package kls_pkg;
    localparam int MAX_KEYS = 64;
    localparam int ADDR_W   = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int FAC_W    = 17;

    localparam logic [2:0] ST_WRITE  = 3'd0;
    localparam logic [2:0] ST_INTERP = 3'd1;
    localparam logic [2:0] ST_SINGLE = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_LAST   = 3'd4;

    localparam logic [7:0] REG_KEY_COUNT   = 8'd0;
    localparam logic [7:0] REG_DEFAULT_ONE = 8'd1;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic start;
        logic [FAC_W-1:0] factor;
    } t_lane_ctl;
endpackage
`default_nettype wire

// ===== rtl/kls_div.sv =====
`default_nettype none
module kls_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [31:0]              i_diff,
    input  wire logic [31:0]              i_den,
    output logic                          o_done,
    output logic [kls_pkg::FAC_W-1:0]     o_quo
);
    logic [32:0] r_rem;
    logic [16:0] r_nb;
    logic [31:0] r_den;
    logic [kls_pkg::FAC_W-1:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done, r_zero;
    logic [32:0] w_t;
    logic        w_ge;

    assign w_t  = {r_rem[31:0], r_nb[16]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(kls_pkg::FAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {2'b00, i_diff[31:1]};
            r_nb   <= {i_diff[0], 16'h0000};
            r_den  <= i_den;
            r_quo  <= '0;
            r_zero <= (i_den == 32'd0);
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_t - {1'b0, r_den}) : w_t;
            r_nb  <= {r_nb[15:0], 1'b0};
            r_quo <= {r_quo[kls_pkg::FAC_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 : r_quo;
endmodule
`default_nettype wire

// ===== rtl/kls_lane.sv =====
`default_nettype none
module kls_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kls_pkg::t_lane_ctl i_ctl,
    input  wire logic [31:0]        i_v0,
    input  wire logic [31:0]        i_v1,
    output logic                    o_valid,
    output logic [31:0]             o_res
);
    logic [2:0]  r_vld;
    logic [31:0] r_v0a, r_v0b;
    logic signed [32:0] r_d;
    logic [kls_pkg::FAC_W-1:0] r_fac;
    logic signed [50:0] r_prod;
    logic signed [34:0] w_sr;
    logic [31:0] r_res;

    assign w_sr = 35'(r_prod >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_ctl.start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0a  <= i_v0;
        r_d    <= $signed({i_v1[31], i_v1}) - $signed({i_v0[31], i_v0});
        r_fac  <= i_ctl.factor;
        r_v0b  <= r_v0a;
        r_prod <= r_d * $signed({1'b0, r_fac});
        r_res  <= r_v0b + w_sr[31:0];
    end

    assign o_valid = r_vld[2];
    assign o_res   = r_res;
endmodule
`default_nettype wire

// ===== rtl/keyframe_linear_sampler_unit.sv =====
// Keyframe linear sampler.
// Input channel (i_in_valid / o_in_stall): one request per accepted item.
// A write request (req_type 0) stores one key; a query (req_type 1) samples
// the key table at query_time. Every request gives one result on the output
// channel (o_out_valid / i_out_stall) with status and three components.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set
// key_count (index 0) and default_is_one (index 1). The user must write them only
// while the block is idle; the block itself does not enforce it. A write or an
// empty-table query passes through S_DONE to the output register. A query
// scans the key memory, one key at a time through its single registered read
// port; when query_time lies between two keys it runs a serial divide for
// the factor and a 3-stage multiply lane per component.
// One request is in work at a time; the next one is taken as soon as the
// result is placed in the output register, even while it waits there.
// Reset clears control state and the configuration registers; the key memory
// is undefined until written. A stalled result holds in the output register.
`default_nettype none
`include "keyframe_linear_sampler_unit_defines.svh"
module keyframe_linear_sampler_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [5:0]  i_key_index,
    input  wire logic [31:0] i_key_time,
    input  wire logic [31:0] i_key_x,
    input  wire logic [31:0] i_key_y,
    input  wire logic [31:0] i_key_z,
    input  wire logic [31:0] i_query_time,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic [31:0]      o_out_z,
    output logic [2:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CHECK = 6'b000100,
        S_DIV   = 6'b001000,
        S_LERP  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [127:0] r_mem [kls_pkg::MAX_KEYS];
    logic [127:0] r_rdata, r_prev;
    logic [kls_pkg::ADDR_W-1:0] r_idx;
    logic [kls_pkg::CNT_W-1:0]  r_n;
    logic [6:0]  r_key_count;
    logic        r_def_one;
    logic [31:0] r_q;
    logic [31:0] r_px, r_py, r_pz;
    logic [2:0]  r_pst;
    logic        r_ovalid;
    logic [31:0] r_ox, r_oy, r_oz;
    logic [2:0]  r_ost;

    logic w_acc, w_hit, w_last, w_div_start, w_div_done, w_load;
    logic [kls_pkg::FAC_W-1:0] w_fac;
    logic [kls_pkg::CNT_W-1:0] w_n;
    logic [31:0] w_t0, w_t1, w_def;
    kls_pkg::t_lane_ctl w_ctl;
    logic [2:0]  w_lvalid;
    logic [31:0] w_lx, w_ly, w_lz;

    assign w_acc  = i_in_valid && !o_in_stall;
    assign w_n    = (32'(r_key_count) > 32'(kls_pkg::MAX_KEYS))
                    ? kls_pkg::CNT_W'(kls_pkg::MAX_KEYS) : kls_pkg::CNT_W'(r_key_count);
    assign w_t0   = r_prev[127:96];
    assign w_t1   = r_rdata[127:96];
    assign w_hit  = (r_q >= w_t0) && (r_q <= w_t1);
    assign w_last = (32'(r_idx) + 32'd1) == 32'(r_n);
    assign w_def  = r_def_one ? kls_pkg::ONE_Q16 : 32'd0;
    assign w_div_start = (r_state == S_CHECK) && (r_idx != '0) && w_hit;
    assign w_ctl.start  = (r_state == S_DIV) && w_div_done;
    assign w_ctl.factor = w_fac;
    assign w_load = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_def_one   <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == kls_pkg::REG_KEY_COUNT) begin
                r_key_count <= i_cfg_data[6:0];
            end else if (i_cfg_index == kls_pkg::REG_DEFAULT_ONE) begin
                r_def_one <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_req_type && (32'(i_key_index) < 32'(kls_pkg::MAX_KEYS))) begin
            r_mem[kls_pkg::ADDR_W'(i_key_index)] <= {i_key_time, i_key_x, i_key_y, i_key_z};
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = (i_req_type && (w_n != '0)) ? S_READ : S_DONE;
                end
            end
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (r_idx == '0) begin
                    n_state = (r_n == kls_pkg::CNT_W'(1)) ? S_DONE : S_READ;
                end else if (w_hit) begin
                    n_state = S_DIV;
                end else if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DIV:   n_state = w_div_done ? S_LERP : S_DIV;
            S_LERP:  n_state = w_lvalid[0] ? S_DONE : S_LERP;
            S_DONE:  n_state = w_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_q   <= i_query_time;
                r_n   <= w_n;
                r_idx <= '0;
                if (!i_req_type) begin
                    {r_px, r_py, r_pz} <= '0;
                    r_pst <= kls_pkg::ST_WRITE;
                end else begin
                    {r_px, r_py, r_pz} <= {w_def, w_def, w_def};
                    r_pst <= kls_pkg::ST_EMPTY;
                end
            end
            S_CHECK: begin
                if (r_idx == '0) begin
                    r_prev <= r_rdata;
                    r_idx  <= r_idx + 1'b1;
                    {r_px, r_py, r_pz} <= r_rdata[95:0];
                    r_pst <= kls_pkg::ST_SINGLE;
                end else if (!w_hit) begin
                    r_prev <= r_rdata;
                    r_idx  <= r_idx + 1'b1;
                    {r_px, r_py, r_pz} <= r_rdata[95:0];
                    r_pst <= kls_pkg::ST_LAST;
                end
            end
            S_LERP: begin
                {r_px, r_py, r_pz} <= {w_lx, w_ly, w_lz};
                r_pst <= kls_pkg::ST_INTERP;
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_ox  <= r_px;
            r_oy  <= r_py;
            r_oz  <= r_pz;
            r_ost <= r_pst;
        end
    end

    kls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_diff  (r_q - w_t0),
        .i_den   (w_t1 - w_t0),
        .o_done  (w_div_done),
        .o_quo   (w_fac)
    );

    kls_lane u_lane_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_v0(r_prev[95:64]), .i_v1(r_rdata[95:64]),
        .o_valid(w_lvalid[0]), .o_res(w_lx)
    );
    kls_lane u_lane_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_v0(r_prev[63:32]), .i_v1(r_rdata[63:32]),
        .o_valid(w_lvalid[1]), .o_res(w_ly)
    );
    kls_lane u_lane_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_v0(r_prev[31:0]), .i_v1(r_rdata[31:0]),
        .o_valid(w_lvalid[2]), .o_res(w_lz)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_z     = r_oz;
    assign o_status    = r_ost;

    `KLS_ASSERT_NEXT(a_acc_busy, w_acc, r_state != S_IDLE)
    `KLS_ASSERT(a_fac_range, !w_div_done || (w_fac <= kls_pkg::FAC_W'(32'h10000)))
    `KLS_ASSERT(a_lanes_even, (w_lvalid == 3'b000) || (w_lvalid == 3'b111))
endmodule
`default_nettype wire

// ===== sim/tb_keyframe_linear_sampler_unit.sv =====
`default_nettype none
module tb_keyframe_linear_sampler_unit;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;
    localparam int   CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [2:0]  st;
    } t_sample;

    typedef struct {
        bit          is_cfg;
        logic [7:0]  cfg_idx;
        logic [7:0]  cfg_data;
        logic        req;
        logic [5:0]  idx;
        logic [31:0] kt;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [31:0] q;
        bit          typed;
        t_sample     exp_res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [5:0]  i_key_index = '0;
    logic [31:0] i_key_time = '0;
    logic [31:0] i_key_x = '0;
    logic [31:0] i_key_y = '0;
    logic [31:0] i_key_z = '0;
    logic [31:0] i_query_time = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;
    logic [2:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    keyframe_linear_sampler_unit uut (.*);

    always #10 i_clk = ~i_clk;

    logic [31:0] key_time_mdl [kls_pkg::MAX_KEYS];
    logic [31:0] key_val_mdl [kls_pkg::MAX_KEYS][3];
    bit          key_loaded [kls_pkg::MAX_KEYS];
    logic [6:0]  key_count_mdl = '0;
    logic        default_one_mdl = 1'b0;

    t_sample     pending_samples [$];
    t_row        directed_rows [$];
    int          mismatches = 0;
    int          requests_sent = 0;
    int          tx_idle = 21;
    int          rx_idle = 67;
    int          cycles = 0;
    int          hold_left = 0;
    bit          pressure_done = 1'b0;

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] f);
        longint d;
        longint p;
        longint r;
        d = longint'(signed'(b)) - longint'(signed'(a));
        p = d * longint'(f);
        r = longint'(signed'(a)) + (p >>> 16);
        return r[31:0];
    endfunction

    function automatic int active_keys();
        return (key_count_mdl > kls_pkg::MAX_KEYS) ? kls_pkg::MAX_KEYS : int'(key_count_mdl);
    endfunction

    function automatic t_sample sample_apply(logic r, logic [5:0] ix, logic [31:0] kt,
                                             logic [31:0] kx, logic [31:0] ky,
                                             logic [31:0] kz, logic [31:0] q);
        t_sample s;
        int n;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [63:0] num;
        logic [16:0] f;
        s = '{32'd0, 32'd0, 32'd0, kls_pkg::ST_WRITE};
        if (r == REQ_WRITE) begin
            key_time_mdl[ix] = kt;
            key_val_mdl[ix][0] = kx;
            key_val_mdl[ix][1] = ky;
            key_val_mdl[ix][2] = kz;
            key_loaded[ix] = 1'b1;
            return s;
        end
        n = active_keys();
        if (n == 0) begin
            s.x = default_one_mdl ? kls_pkg::ONE_Q16 : 32'd0;
            s.y = s.x;
            s.z = s.x;
            s.st = kls_pkg::ST_EMPTY;
            return s;
        end
        if (n == 1) begin
            return '{key_val_mdl[0][0], key_val_mdl[0][1], key_val_mdl[0][2],
                     kls_pkg::ST_SINGLE};
        end
        for (int i = 0; i + 1 < n; i++) begin
            t0 = key_time_mdl[i];
            t1 = key_time_mdl[i+1];
            if (q >= t0 && q <= t1) begin
                f = '0;
                if (t1 != t0) begin
                    num = 64'(q - t0) << 16;
                    f = 17'(num / 64'(t1 - t0));
                end
                s.x = blend(key_val_mdl[i][0], key_val_mdl[i+1][0], f);
                s.y = blend(key_val_mdl[i][1], key_val_mdl[i+1][1], f);
                s.z = blend(key_val_mdl[i][2], key_val_mdl[i+1][2], f);
                s.st = kls_pkg::ST_INTERP;
                return s;
            end
        end
        return '{key_val_mdl[n-1][0], key_val_mdl[n-1][1], key_val_mdl[n-1][2],
                 kls_pkg::ST_LAST};
    endfunction

    task automatic put_request(input logic r, input logic [5:0] ix, input logic [31:0] kt,
                               input logic [31:0] kx, input logic [31:0] ky,
                               input logic [31:0] kz, input logic [31:0] q,
                               input bit typed, input t_sample ex);
        t_sample pr;
        bit took;
        if (tx_idle > 0 && $urandom_range(0, 99) < tx_idle) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= r;
        i_key_index  <= ix;
        i_key_time   <= kt;
        i_key_x      <= kx;
        i_key_y      <= ky;
        i_key_z      <= kz;
        i_query_time <= q;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end
        pr = sample_apply(r, ix, kt, kx, ky, kz, q);
        pending_samples.push_back(typed ? ex : pr);
        requests_sent++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        bit took;
        i_in_valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        if (idx == kls_pkg::REG_KEY_COUNT) key_count_mdl = data[6:0];
        else if (idx == kls_pkg::REG_DEFAULT_ONE) default_one_mdl = data[0];
    endtask

    function automatic logic [31:0] rand_key_time(int slot);
        if ($urandom_range(0, 3) == 0) return $urandom;
        return slot * 32'h0004_0000 + $urandom_range(0, 32'h0003_ffff);
    endfunction

    task automatic random_write(input int slot);
        t_sample none;
        none = '{32'd0, 32'd0, 32'd0, kls_pkg::ST_WRITE};
        put_request(REQ_WRITE, 6'(slot), rand_key_time(slot), $urandom, $urandom, $urandom,
                    $urandom, 1'b0, none);
    endtask

    task automatic random_query();
        t_sample none;
        int n;
        int i;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] q;
        int pick;
        none = '{32'd0, 32'd0, 32'd0, kls_pkg::ST_WRITE};
        n = active_keys();
        pick = $urandom_range(0, 9);
        q = $urandom;
        if (n >= 2 && pick < 6) begin
            i = $urandom_range(0, n - 2);
            lo = key_time_mdl[i];
            hi = key_time_mdl[i+1];
            if (hi >= lo) q = lo + $urandom_range(0, hi - lo);
        end else if (n >= 1 && pick == 6) begin
            q = key_time_mdl[$urandom_range(0, n - 1)];
        end
        put_request(REQ_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, q,
                    1'b0, none);
    endtask

    function automatic void add_cfg(logic [7:0] idx, logic [7:0] data);
        t_row rw;
        rw = '{default: '0};
        rw.is_cfg = 1'b1;
        rw.cfg_idx = idx;
        rw.cfg_data = data;
        directed_rows.push_back(rw);
    endfunction

    function automatic void add_req(logic r, logic [5:0] ix, logic [31:0] kt, logic [31:0] kx,
                                    logic [31:0] ky, logic [31:0] kz, logic [31:0] q,
                                    bit typed, t_sample ex);
        t_row rw;
        rw = '{default: '0};
        rw.req = r;
        rw.idx = ix;
        rw.kt = kt;
        rw.kx = kx;
        rw.ky = ky;
        rw.kz = kz;
        rw.q = q;
        rw.typed = typed;
        rw.exp_res = ex;
        directed_rows.push_back(rw);
    endfunction

    task automatic note_mismatch(input string what, input t_sample ex);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                     what, ex.x, ex.y, ex.z, ex.st, o_out_x, o_out_y, o_out_z, o_status);
    endtask

    always @(negedge i_clk) begin
        t_sample ex;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                ex = '{32'd0, 32'd0, 32'd0, kls_pkg::ST_WRITE};
                note_mismatch("unexpected result", ex);
            end else begin
                ex = pending_samples.pop_front();
                if (o_out_x !== ex.x || o_out_y !== ex.y || o_out_z !== ex.z ||
                    o_status !== ex.st)
                    note_mismatch("result", ex);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!pressure_done && requests_sent >= 400) begin
            i_out_stall <= 1'b1;
            hold_left <= 600;
            pressure_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_keyframe_linear_sampler_unit: done, errors");
            $finish;
        end
    end

    initial begin
        int counts [12] = '{0, 1, 2, 127, 64, 7, 9, 33, 2, 64, 5, 1};
        int n;
        t_sample z0;
        t_sample wr;
        t_row rw;
        z0 = '{32'd0, 32'd0, 32'd0, kls_pkg::ST_WRITE};
        wr = z0;
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                '{32'd0, 32'd0, 32'd0, kls_pkg::ST_EMPTY});
        add_cfg(kls_pkg::REG_DEFAULT_ONE, 8'd1);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hffff_ffff, 1'b1,
                '{kls_pkg::ONE_Q16, kls_pkg::ONE_Q16, kls_pkg::ONE_Q16, kls_pkg::ST_EMPTY});
        add_req(REQ_WRITE, 6'd0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                32'hffff_ffff, 1'b1, wr);
        add_req(REQ_WRITE, 6'd63, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd0,
                32'd0, 1'b1, wr);
        add_cfg(kls_pkg::REG_KEY_COUNT, 8'd1);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_2345, 1'b1,
                '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, kls_pkg::ST_SINGLE});
        add_req(REQ_WRITE, 6'd1, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
                32'd0, 1'b1, wr);
        add_cfg(kls_pkg::REG_KEY_COUNT, 8'd2);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b0, z0);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0003_0000, 1'b0, z0);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0002_0000, 1'b0, z0);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0002_aaaa, 1'b0, z0);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                '{32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, kls_pkg::ST_LAST});
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hffff_ffff, 1'b1,
                '{32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, kls_pkg::ST_LAST});
        add_req(REQ_WRITE, 6'd1, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
                32'd0, 1'b1, wr);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b0, z0);
        add_req(REQ_WRITE, 6'd1, 32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
                32'd0, 1'b1, wr);
        add_req(REQ_WRITE, 6'd2, 32'h0002_0000, 32'd1, 32'd2, 32'd3, 32'd0, 1'b1, wr);
        add_cfg(kls_pkg::REG_KEY_COUNT, 8'd3);
        add_req(REQ_SAMPLE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_8000, 1'b0, z0);
        add_cfg(kls_pkg::REG_DEFAULT_ONE, 8'd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            rw = directed_rows[k];
            if (rw.is_cfg) write_reg(rw.cfg_idx, rw.cfg_data);
            else put_request(rw.req, rw.idx, rw.kt, rw.kx, rw.ky, rw.kz, rw.q,
                             rw.typed, rw.exp_res);
        end

        for (int p = 0; p < 12; p++) begin
            tx_idle = (p < 4) ? 21 : (p < 8) ? 67 : 0;
            rx_idle = (p < 4) ? 67 : (p < 8) ? 21 : 0;
            write_reg(kls_pkg::REG_KEY_COUNT, 8'(counts[p]));
            write_reg(kls_pkg::REG_DEFAULT_ONE, 8'(p % 2));
            n = active_keys();
            for (int s = 0; s < n; s++)
                if (!key_loaded[s] || $urandom_range(0, 3) == 0) random_write(s);
            for (int k = 0; k < 78; k++) begin
                if ($urandom_range(0, 4) == 0)
                    random_write($urandom_range(0, kls_pkg::MAX_KEYS - 1));
                else random_query();
            end
        end

        i_in_valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_samples.size() == 0)
            $display("tb_keyframe_linear_sampler_unit: done, clean");
        else
            $display("tb_keyframe_linear_sampler_unit: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== keyframe_linear_sampler_unit.f =====
+incdir+rtl
rtl/kls_pkg.sv
rtl/kls_div.sv
rtl/kls_lane.sv
rtl/keyframe_linear_sampler_unit.sv
sim/tb_keyframe_linear_sampler_unit.sv
